// ===== src/lpfm_pkg.sv =====
package lpfm_pkg;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] peak_value;
    logic [9:0]  peak_index;
    logic [9:0]  left_index;
    logic [9:0]  right_index;
    logic [17:0] fwhm_q8;
    logic        ok;
  } out_item_t;

  localparam logic [7:0]  MARGIN_RESET = 8'd50;
  localparam logic [17:0] FWHM_MAX     = 18'd262143;
  localparam int          QUEUE_DEPTH  = 2;

endpackage

// ===== src/lpfm_ram.sv =====
module lpfm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lpfm_front.sv =====
// Front part: takes items, writes samples into the line store and, on a
// last flag, pushes a measurement job (line length) into a short queue.
module lpfm_front #(
  parameter int LINE_MAX    = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int AW          = 10,
  parameter int NW          = 11
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  lpfm_pkg::in_item_t     item,
  input  logic                   pop,
  output logic                   we,
  output logic [AW-1:0]          waddr,
  output logic [SAMPLE_BITS-1:0] wdata,
  output logic                   job_valid,
  output logic [NW-1:0]          job_len,
  output logic                   full
);

  localparam int QD = lpfm_pkg::QUEUE_DEPTH;

  logic [NW-1:0] fill_count;
  logic [NW-1:0] fill_next;
  logic [NW-1:0] q_len [QD];
  logic [1:0]    q_count;
  logic          q_wp;
  logic          q_rp;
  logic          push;

  assign fill_next = (fill_count < NW'(LINE_MAX)) ? fill_count + NW'(1) : fill_count;
  assign we    = take && (fill_count < NW'(LINE_MAX));
  assign waddr = fill_count[AW-1:0];
  assign wdata = item.sample[SAMPLE_BITS-1:0];
  assign push  = take && item.last;
  assign job_valid = (q_count != 2'd0);
  assign job_len   = q_len[q_rp];
  // full rises as soon as one job is queued, so the top holds off new items and
  // the store never sees a new line overwrite samples still under measurement.
  assign full = (q_count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      q_count    <= '0;
      q_wp       <= 1'b0;
      q_rp       <= 1'b0;
    end else begin
      if (take) begin
        fill_count <= item.last ? '0 : fill_next;
      end
      if (push) begin
        q_len[q_wp] <= fill_next;
        q_wp        <= ~q_wp;
      end
      if (pop) begin
        q_rp <= ~q_rp;
      end
      q_count <= q_count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== src/lpfm_back.sv =====
// Back part: sequencer that scans the stored line for the peak, walks both
// ways to the half-max crossings and runs a restoring divider per fraction.
module lpfm_back #(
  parameter int SAMPLE_BITS = 16,
  parameter int AW          = 10,
  parameter int NW          = 11
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [7:0]             margin,
  input  logic                   job_valid,
  input  logic [NW-1:0]          job_len,
  output logic                   pop,
  output logic [AW-1:0]          raddr,
  input  logic [SAMPLE_BITS-1:0] rdata,
  output logic                   done,
  output lpfm_pkg::out_item_t    result
);

  localparam int SB = SAMPLE_BITS;
  localparam int IW = NW + 1;
  localparam int DW = SB + 2;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_LWALK = 4'd2;
  localparam logic [3:0] S_RWALK = 4'd3;
  localparam logic [3:0] S_FETCH = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_SUM   = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  logic [3:0]    state;
  logic [IW-1:0] lo, hi, idx, pk, left, right;
  logic [SB-1:0] peak;
  logic          vld;
  logic [2:0]    fstep;
  logic [SB-1:0] v_left, v_lin, v_right, v_rin;
  logic          side;
  logic [DW-1:0] den, rem;
  logic [8:0]    quo;
  logic [3:0]    dcnt;
  logic [8:0]    tl, tr;
  logic [8:0]    frac;
  logic          short_line;
  logic [SB:0]   twice;
  logic [IW-1:0] iaddr;
  logic [DW-1:0] rem_sh;
  logic [DW-1:0] n_c, d_c;
  logic [IW+8:0] fw;

  assign twice = {rdata, 1'b0};
  assign raddr = iaddr[AW-1:0];
  assign pop   = (state == S_IDLE) && job_valid;
  assign rem_sh = {rem[DW-2:0], 1'b0};

  always_comb begin
    iaddr = idx;
    if (state == S_FETCH) begin
      unique case (fstep)
        3'd0:    iaddr = left;
        3'd1:    iaddr = (left + IW'(1) < pk) ? left + IW'(1) : pk;
        3'd2:    iaddr = right;
        default: iaddr = (right - IW'(1) > pk) ? right - IW'(1) : pk;
      endcase
    end
  end

  // Signed numerator and denominator of one crossing fraction.
  always_comb begin
    if (side == 1'b0) begin
      n_c = DW'(peak) - {1'b0, v_left, 1'b0};
      d_c = {1'b0, v_lin, 1'b0} - {1'b0, v_left, 1'b0};
    end else begin
      n_c = DW'(peak) - {1'b0, v_right, 1'b0};
      d_c = {1'b0, v_rin, 1'b0} - {1'b0, v_right, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            short_line <= ({1'b0, job_len} <= {margin, 1'b0});
            lo  <= IW'(margin);
            hi  <= IW'(job_len) - IW'(margin) - IW'(1);
            idx <= IW'(margin);
            vld <= 1'b0;
            if ({1'b0, job_len} <= {margin, 1'b0}) begin
              state <= S_OUT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // vld marks that rdata holds the sample at idx - 1.
          vld <= 1'b1;
          if (vld) begin
            if (idx - IW'(1) == lo || rdata > peak) begin
              peak <= rdata;
              pk   <= idx - IW'(1);
            end
          end
          if (vld && idx - IW'(1) == hi) begin
            state <= S_LWALK;
            vld   <= 1'b0;
          end else begin
            idx <= idx + IW'(1);
          end
          if (vld && idx - IW'(1) == hi) begin
            idx  <= (rdata > peak) ? idx - IW'(2) : pk - IW'(1);
            left <= lo;
          end
        end
        S_LWALK: begin
          if (pk == lo) begin
            left  <= lo;
            idx   <= pk + IW'(1);
            vld   <= 1'b0;
            state <= S_RWALK;
          end else begin
            vld <= 1'b1;
            if (vld) begin
              if ({1'b0, twice} <= (SB+1)'(peak) || idx + IW'(1) == lo) begin
                left  <= ({1'b0, twice} <= (SB+1)'(peak)) ? idx + IW'(1) : lo;
                idx   <= pk + IW'(1);
                vld   <= 1'b0;
                state <= S_RWALK;
              end else begin
                idx <= idx - IW'(1);
              end
            end else begin
              idx <= idx - IW'(1);
            end
          end
        end
        S_RWALK: begin
          if (pk == hi) begin
            right <= hi;
            fstep <= '0;
            state <= S_FETCH;
          end else begin
            vld <= 1'b1;
            if (vld) begin
              if ({1'b0, twice} <= (SB+1)'(peak) || idx - IW'(1) == hi) begin
                right <= ({1'b0, twice} <= (SB+1)'(peak)) ? idx - IW'(1) : hi;
                fstep <= '0;
                state <= S_FETCH;
              end else begin
                idx <= idx + IW'(1);
              end
            end else begin
              idx <= idx + IW'(1);
            end
          end
        end
        S_FETCH: begin
          // Address fstep issued this cycle; data of fstep-1 arrives now.
          unique case (fstep)
            3'd1:    v_left  <= rdata;
            3'd2:    v_lin   <= rdata;
            3'd3:    v_right <= rdata;
            3'd4:    v_rin   <= rdata;
            default: ;
          endcase
          if (fstep == 3'd4) begin
            side  <= 1'b0;
            dcnt  <= '0;
            state <= S_DIV;
          end else begin
            fstep <= fstep + 3'd1;
          end
        end
        S_DIV: begin
          if (dcnt == 4'd0) begin
            if (n_c[DW-1] || n_c == '0) begin
              frac <= 9'd0;
              dcnt <= 4'd10;
            end else if (d_c[DW-1] || d_c <= n_c) begin
              frac <= 9'd256;
              dcnt <= 4'd10;
            end else begin
              den  <= d_c;
              rem  <= n_c;
              quo  <= '0;
              dcnt <= 4'd1;
            end
          end else if (dcnt <= 4'd8) begin
            // One quotient bit per cycle of num*256/den, num < den.
            if (rem_sh >= den) begin
              rem <= rem_sh - den;
              quo <= {quo[7:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[7:0], 1'b0};
            end
            dcnt <= dcnt + 4'd1;
            if (dcnt == 4'd8) begin
              dcnt <= 4'd9;
            end
          end else begin
            if (side == 1'b0) begin
              tl <= (dcnt == 4'd9) ? quo : frac;
              side <= 1'b1;
              dcnt <= '0;
            end else begin
              tr <= (dcnt == 4'd9) ? quo : frac;
              state <= S_SUM;
            end
          end
        end
        S_SUM: begin
          state <= S_OUT;
        end
        S_OUT: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (short_line) begin
            result <= '0;
          end else begin
            result.peak_value  <= 16'(peak);
            result.peak_index  <= 10'(pk);
            result.left_index  <= 10'(left);
            result.right_index <= 10'(right);
            result.fwhm_q8     <= fw[IW+8] ? '0
                               : (fw > (IW+9)'(lpfm_pkg::FWHM_MAX)) ? lpfm_pkg::FWHM_MAX
                               : fw[17:0];
            result.ok          <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign fw = {1'b0, right - left, 8'd0} - (IW+9)'(tl) - (IW+9)'(tr);

endmodule

// ===== src/line_peak_fwhm_measure_unit.sv =====
// Channel   Handshake               Payload
// in        start / busy            in_item (sample, last)
// out       strobe, one cycle       out_item (peak, indices, fwhm_q8, ok)
// cfg       cfg_valid / cfg_ready   cfg_data (edge_margin)
//
// Loading takes one sample per cycle while busy is low. After the last sample the
// back part scans the inner range, walks both sides to the crossings and fetches
// four samples, all through the single read port of the line store, then runs
// two 8-step dividers. One job waits in the queue; busy stays high while a line
// waits or is measured. Reset is synchronous and sets edge_margin to 50. The
// receiver cannot stall results.
module line_peak_fwhm_measure_unit #(
  parameter int LINE_MAX    = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  lpfm_pkg::in_item_t  in_item,
  output logic                strobe,
  output lpfm_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  localparam int AW = $clog2(LINE_MAX);
  localparam int NW = AW + 1;

  logic [7:0]             margin;
  logic                   take, we, job_valid, pop, full;
  logic [AW-1:0]          waddr, raddr;
  logic [SAMPLE_BITS-1:0] wdata, rdata;
  logic [NW-1:0]          job_len;

  assign cfg_ready = 1'b1;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      margin <= lpfm_pkg::MARGIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      margin <= cfg_data;
    end
  end

  // The store holds one line; a new line may load only once its result is out.
  logic back_busy;
  assign busy = full || back_busy;

  lpfm_front #(.LINE_MAX(LINE_MAX), .SAMPLE_BITS(SAMPLE_BITS), .AW(AW), .NW(NW)) u_front (
    .clk, .rst, .take, .item(in_item), .pop, .we, .waddr, .wdata,
    .job_valid, .job_len, .full
  );

  lpfm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(LINE_MAX)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  lpfm_back #(.SAMPLE_BITS(SAMPLE_BITS), .AW(AW), .NW(NW)) u_back (
    .clk, .rst, .margin, .job_valid, .job_len, .pop, .raddr, .rdata,
    .done(strobe), .result(out_item)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      back_busy <= 1'b0;
    end else if (pop) begin
      back_busy <= 1'b1;
    end else if (strobe) begin
      back_busy <= 1'b0;
    end
  end

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    pop |=> busy) else $error("item taken while a line is measured");
  a_ok_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && !out_item.ok |-> out_item.fwhm_q8 == '0) else $error("bad short line");
  a_order: assert property (@(posedge clk) disable iff (rst)
    strobe && out_item.ok |-> out_item.left_index <= out_item.peak_index)
    else $error("left crossing past peak");

endmodule
